>>> src/ogn_pkg.sv
// Shared constants, codes and control types of the octave gradient noise block.
package ogn_pkg;

   localparam int FRAC_BITS_DEF   = 16;
   localparam int MAX_OCTAVES_DEF = 8;
   localparam int IN_W            = 32;
   localparam int OUT_W           = 16;
   localparam int SEED_W          = 32;
   localparam int OCT_CFG_W       = 4;
   localparam int AMP_W           = 17;
   localparam int QUOT_W          = 17;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 32;
   localparam int HASH_W          = 32;
   localparam int GRAD_SEL_W      = 4;

   localparam logic [AMP_W-1:0] AMP_ONE  = AMP_W'(65536);
   localparam logic [AMP_W-1:0] PERS_RST = AMP_W'(32768);
   localparam logic [OUT_W-1:0] RES_MAX  = {OUT_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEED    = 2'd0,
      CSR_OCTAVES = 2'd1,
      CSR_PERSIST = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic go;
      logic q16;
   } mul_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

>>> src/ogn_if.sv
// Channel interfaces: point request, noise response and register write.
interface ogn_req_if import ogn_pkg::*; ;
   logic                    valid;
   logic                    ready;
   logic signed [IN_W-1:0]  point_x;
   logic signed [IN_W-1:0]  point_y;
   logic signed [IN_W-1:0]  point_z;
   modport source (output valid, point_x, point_y, point_z, input ready);
   modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface ogn_rsp_if import ogn_pkg::*; ;
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] noise_value;
   modport source (output valid, noise_value, input ready);
   modport sink   (input valid, noise_value, output ready);
endinterface

interface ogn_csr_if import ogn_pkg::*; ;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> src/octave_gradient_noise_3d_top.sv
// Fractal 3D gradient noise: sequencer around a shared hash, multiplier and divider.
// Each octave runs the corner hash rounds, the fade curves, the blend and the accumulate;
// a final pass scales the total, runs the 17-step division and posts the result word.
// One point is worked at a time; req ready is high only when the sequencer is idle,
// so a point is taken only after the last result is posted; saturation skips the division.
// Synchronous reset sets seed 0, one octave and persistence one half; no clearing pass.
module octave_gradient_noise_3d_top import ogn_pkg::*; #(
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
   input logic        clock,
   input logic        reset,
   ogn_req_if.sink    req_ch,
   ogn_rsp_if.source  rsp_ch,
   ogn_csr_if.sink    csr_ch
);

   localparam int CW = IN_W + MAX_OCTAVES;
   localparam int LW = CW + 1;
   localparam int MW = FRAC_BITS + 18;
   localparam int FW = FRAC_BITS + 2;
   localparam int GW = FW + 1;
   localparam int OW = $clog2(MAX_OCTAVES) + 1;
   localparam int XW = AMP_W + $clog2(MAX_OCTAVES + 1);
   localparam int TW = MW + $clog2(MAX_OCTAVES + 1);
   localparam int SW = TW + 16;
   localparam int NW = XW + QUOT_W;
   localparam int SH_DN = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
   localparam int SH_UP = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

   localparam logic signed [LW-1:0] ONE_L     = LW'(1) <<< FRAC_BITS;
   localparam logic signed [FW-1:0] ONE_F     = FW'(1) <<< FRAC_BITS;
   localparam logic signed [MW-1:0] ONE_M     = MW'(1) <<< FRAC_BITS;
   localparam logic signed [MW-1:0] TEN_M     = MW'(10) <<< FRAC_BITS;
   localparam logic signed [MW-1:0] FIFTEEN_M = MW'(15) <<< FRAC_BITS;
   localparam logic signed [SW-1:0] T_RND     = (SW'(1) <<< SH_DN) >>> 1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_HASH, ST_FADE, ST_BLEND, ST_ACC, ST_FINAL, ST_DECIDE, ST_DIV, ST_DONE
   } state_type;

   state_type               state_ff;
   logic [SEED_W-1:0]       seed_ff;
   logic [OCT_CFG_W-1:0]    octs_ff;
   logic [AMP_W-1:0]        pers_cfg_ff;

   logic signed [CW-1:0]    c_ff [3];
   logic [OW-1:0]           cnt_ff;
   logic [OW-1:0]           oct_ff;
   logic [AMP_W-1:0]        pers_ff;
   logic [AMP_W-1:0]        amp_ff;
   logic [XW-1:0]           maxv_ff;
   logic signed [TW-1:0]    total_ff;
   logic signed [SW-1:0]    t16_ff;
   logic [3:0]              step_ff;
   logic [2:0]              corner_ff;
   logic [1:0]              round_ff;
   logic [1:0]              axis_ff;
   logic                    cap_ff;
   logic [2:0]              cap_k_ff;
   logic [GRAD_SEL_W-1:0]   h_ff [8];
   logic signed [MW-1:0]    s2_ff;
   logic signed [MW-1:0]    sin_ff;
   logic signed [MW-1:0]    fd_ff [3];
   logic signed [MW-1:0]    bv_ff [7];
   logic                    rsp_valid_ff;
   logic [OUT_W-1:0]        res_ff;
   logic [OUT_W-1:0]        pend_ff;

   logic signed [FW-1:0]    fr [3];
   logic signed [FW-1:0]    gr [3];
   logic [HASH_W-1:0]       lat0 [3];
   logic [HASH_W-1:0]       lat1 [3];
   logic signed [GW-1:0]    gv [8];
   logic [HASH_W-1:0]       hash_a;
   logic [HASH_W-1:0]       hash_b;
   logic [HASH_W-1:0]       hash_out;
   logic                    hash_go;
   mul_ctl_type             mctl;
   logic signed [MW-1:0]    ma;
   logic signed [MW-1:0]    mb;
   logic signed [MW-1:0]    prod;
   logic signed [MW-1:0]    t_sel;
   logic signed [MW-1:0]    six;
   logic signed [MW-1:0]    b_lo;
   logic signed [MW-1:0]    b_hi;
   logic signed [MW-1:0]    b_t;
   logic signed [MW-1:0]    noise;
   logic signed [SW-1:0]    t16;
   logic signed [SW-1:0]    maxv_s;
   logic [NW-1:0]           num;
   logic                    div_go;
   logic [QUOT_W-1:0]       quot;
   div_sts_type             dsts;
   logic                    req_acc;
   logic                    rsp_acc;

   function automatic logic signed [LW-1:0] trunc_l(input logic signed [LW-1:0] v);
      logic signed [LW-1:0] m;
      m = (v < 0) ? -v : v;
      m = m >>> FRAC_BITS;
      return (v < 0) ? -m : m;
   endfunction

   assign req_acc = req_ch.valid && req_ch.ready;
   assign rsp_acc = rsp_ch.valid && rsp_ch.ready;

   assign csr_ch.ready      = 1'b1;
   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.noise_value = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff     <= '0;
         octs_ff     <= OCT_CFG_W'(1);
         pers_cfg_ff <= PERS_RST;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_SEED:    seed_ff     <= csr_ch.data[SEED_W-1:0];
            CSR_OCTAVES: octs_ff     <= csr_ch.data[OCT_CFG_W-1:0];
            CSR_PERSIST: pers_cfg_ff <= csr_ch.data[AMP_W-1:0];
            default: ;
         endcase
      end
   end

   // Lattice cell and fractions of the current octave's coordinates.
   always_comb begin
      logic signed [LW-1:0] v;
      logic signed [LW-1:0] i0;
      logic signed [LW-1:0] i1;
      logic signed [LW-1:0] f;
      for (int a = 0; a < 3; a++) begin
         v       = LW'(c_ff[a]);
         i0      = trunc_l(v);
         i1      = trunc_l(v + ONE_L);
         f       = v - (i0 <<< FRAC_BITS);
         fr[a]   = f[FW-1:0];
         gr[a]   = f[FW-1:0] - ONE_F;
         lat0[a] = i0[HASH_W-1:0];
         lat1[a] = i1[HASH_W-1:0];
      end
   end

   always_comb begin
      logic signed [GW-1:0] xs;
      logic signed [GW-1:0] ys;
      logic signed [GW-1:0] zs;
      for (int k = 0; k < 8; k++) begin
         xs = GW'(k[0] ? gr[0] : fr[0]);
         ys = GW'(k[1] ? gr[1] : fr[1]);
         zs = GW'(k[2] ? gr[2] : fr[2]);
         case (h_ff[k])
            4'h0:    gv[k] = xs + ys;
            4'h1:    gv[k] = -xs + ys;
            4'h2:    gv[k] = xs - ys;
            4'h3:    gv[k] = -xs - ys;
            4'h4:    gv[k] = xs + zs;
            4'h5:    gv[k] = -xs + zs;
            4'h6:    gv[k] = xs - zs;
            4'h7:    gv[k] = -xs - zs;
            4'h8:    gv[k] = ys + zs;
            4'h9:    gv[k] = -ys + zs;
            4'hA:    gv[k] = ys - zs;
            4'hB:    gv[k] = -ys - zs;
            4'hC:    gv[k] = ys + xs;
            4'hD:    gv[k] = -ys + zs;
            4'hE:    gv[k] = ys - xs;
            default: gv[k] = -ys - zs;
         endcase
      end
   end

   always_comb begin
      hash_go = (state_ff == ST_HASH);
      case (round_ff)
         2'd0: begin
            hash_a = corner_ff[0] ? lat1[0] : lat0[0];
            hash_b = seed_ff;
         end
         2'd1: begin
            hash_a = hash_out;
            hash_b = corner_ff[1] ? lat1[1] : lat0[1];
         end
         default: begin
            hash_a = hash_out;
            hash_b = corner_ff[2] ? lat1[2] : lat0[2];
         end
      endcase
   end

   ogn_hash u_hash (
      .clock (clock),
      .go    (hash_go),
      .a     (hash_a),
      .b     (hash_b),
      .hash  (hash_out)
   );

   always_comb begin
      case (axis_ff)
         2'd0:    t_sel = MW'(fr[0]);
         2'd1:    t_sel = MW'(fr[1]);
         default: t_sel = MW'(fr[2]);
      endcase
      six = (t_sel <<< 2) + (t_sel <<< 1) - FIFTEEN_M;
      case (step_ff[3:1])
         3'd0: begin
            b_lo = MW'(gv[0]); b_hi = MW'(gv[1]); b_t = fd_ff[0];
         end
         3'd1: begin
            b_lo = MW'(gv[2]); b_hi = MW'(gv[3]); b_t = fd_ff[0];
         end
         3'd2: begin
            b_lo = bv_ff[0]; b_hi = bv_ff[1]; b_t = fd_ff[1];
         end
         3'd3: begin
            b_lo = MW'(gv[4]); b_hi = MW'(gv[5]); b_t = fd_ff[0];
         end
         3'd4: begin
            b_lo = MW'(gv[6]); b_hi = MW'(gv[7]); b_t = fd_ff[0];
         end
         3'd5: begin
            b_lo = bv_ff[3]; b_hi = bv_ff[4]; b_t = fd_ff[1];
         end
         default: begin
            b_lo = bv_ff[2]; b_hi = bv_ff[5]; b_t = fd_ff[2];
         end
      endcase
      noise = (bv_ff[6] + ONE_M) >>> 1;

      mctl = '0;
      ma   = '0;
      mb   = '0;
      case (state_ff)
         ST_FADE: begin
            mctl.go = (step_ff != 4'd4);
            case (step_ff)
               4'd0:    begin ma = t_sel; mb = t_sel;  end
               4'd1:    begin ma = t_sel; mb = six;    end
               4'd2:    begin ma = s2_ff; mb = t_sel;  end
               default: begin ma = prod;  mb = sin_ff; end
            endcase
         end
         ST_BLEND: begin
            mctl.go = !step_ff[0];
            ma      = b_t;
            mb      = b_hi - b_lo;
         end
         ST_ACC: begin
            mctl.go  = (step_ff != 4'd2);
            mctl.q16 = 1'b1;
            if (step_ff == 4'd0) begin
               ma = noise;
               mb = MW'(amp_ff);
            end else begin
               ma = MW'(amp_ff);
               mb = MW'(pers_ff);
            end
         end
         default: ;
      endcase
   end

   ogn_mul #(
      .FRAC_BITS (FRAC_BITS),
      .MW        (MW)
   ) u_mul (
      .clock (clock),
      .ctl   (mctl),
      .a     (ma),
      .b     (mb),
      .prod  (prod)
   );

   always_comb begin
      t16    = ((SW'(total_ff) <<< SH_UP) + T_RND) >>> SH_DN;
      maxv_s = SW'({1'b0, maxv_ff});
      num    = NW'({t16_ff[XW-1:0], 16'h0}) + NW'(maxv_ff >> 1);
      div_go = (state_ff == ST_DECIDE) && (t16_ff > 0) && (t16_ff < maxv_s);
   end

   ogn_div #(
      .XW (XW)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .go     (div_go),
      .num_hi (num[NW-1:QUOT_W]),
      .num_lo (num[QUOT_W-1:0]),
      .den    (maxv_ff),
      .quot   (quot),
      .sts    (dsts)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= 1'b0;
      end else begin
         cap_ff   <= hash_go && (round_ff == 2'd2);
         cap_k_ff <= corner_ff;
         if (cap_ff) begin
            h_ff[cap_k_ff] <= hash_out[GRAD_SEL_W-1:0];
         end
         if (rsp_acc && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  c_ff[0]   <= CW'(req_ch.point_x);
                  c_ff[1]   <= CW'(req_ch.point_y);
                  c_ff[2]   <= CW'(req_ch.point_z);
                  if (octs_ff == '0) begin
                     cnt_ff <= OW'(1);
                  end else if (int'(octs_ff) > MAX_OCTAVES) begin
                     cnt_ff <= OW'(MAX_OCTAVES);
                  end else begin
                     cnt_ff <= OW'(octs_ff);
                  end
                  pers_ff   <= (pers_cfg_ff > AMP_ONE) ? AMP_ONE : pers_cfg_ff;
                  amp_ff    <= AMP_ONE;
                  maxv_ff   <= '0;
                  total_ff  <= '0;
                  oct_ff    <= '0;
                  corner_ff <= '0;
                  round_ff  <= '0;
                  state_ff  <= ST_HASH;
               end
            end
            ST_HASH: begin
               if (round_ff == 2'd2) begin
                  round_ff  <= '0;
                  corner_ff <= corner_ff + 1'b1;
                  if (corner_ff == 3'd7) begin
                     axis_ff  <= '0;
                     step_ff  <= '0;
                     state_ff <= ST_FADE;
                  end
               end else begin
                  round_ff <= round_ff + 1'b1;
               end
            end
            ST_FADE: begin
               step_ff <= (step_ff == 4'd4) ? 4'd0 : step_ff + 1'b1;
               case (step_ff)
                  4'd1: s2_ff  <= prod;
                  4'd2: sin_ff <= prod + TEN_M;
                  4'd4: begin
                     fd_ff[axis_ff] <= prod;
                     axis_ff        <= axis_ff + 1'b1;
                     if (axis_ff == 2'd2) begin
                        state_ff <= ST_BLEND;
                     end
                  end
                  default: ;
               endcase
            end
            ST_BLEND: begin
               step_ff <= (step_ff == 4'd13) ? 4'd0 : step_ff + 1'b1;
               if (step_ff[0]) begin
                  bv_ff[step_ff[3:1]] <= b_lo + prod;
               end
               if (step_ff == 4'd13) begin
                  state_ff <= ST_ACC;
               end
            end
            ST_ACC: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == 4'd1) begin
                  total_ff <= total_ff + TW'(prod);
                  maxv_ff  <= maxv_ff + XW'(amp_ff);
               end else if (step_ff == 4'd2) begin
                  amp_ff    <= prod[AMP_W-1:0];
                  c_ff[0]   <= c_ff[0] <<< 1;
                  c_ff[1]   <= c_ff[1] <<< 1;
                  c_ff[2]   <= c_ff[2] <<< 1;
                  corner_ff <= '0;
                  round_ff  <= '0;
                  if (oct_ff == OW'(cnt_ff - 1'b1)) begin
                     state_ff <= ST_FINAL;
                  end else begin
                     oct_ff   <= oct_ff + 1'b1;
                     state_ff <= ST_HASH;
                  end
               end
            end
            ST_FINAL: begin
               t16_ff   <= t16;
               state_ff <= ST_DECIDE;
            end
            ST_DECIDE: begin
               if (t16_ff <= 0) begin
                  pend_ff  <= '0;
                  state_ff <= ST_DONE;
               end else if (t16_ff >= maxv_s) begin
                  pend_ff  <= RES_MAX;
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (dsts.done) begin
                  pend_ff  <= quot[QUOT_W-1] ? RES_MAX : quot[OUT_W-1:0];
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_acc) begin
                  res_ff       <= pend_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

>>> src/ogn_hash.sv
// One round of the seeded xorshift corner hash per cycle while go is high.
module ogn_hash import ogn_pkg::*; (
   input  logic              clock,
   input  logic              go,
   input  logic [HASH_W-1:0] a,
   input  logic [HASH_W-1:0] b,
   output logic [HASH_W-1:0] hash
);

   logic [HASH_W-1:0] hash_ff;

   function automatic logic [HASH_W-1:0] xs32(input logic [HASH_W-1:0] v);
      logic [HASH_W-1:0] r;
      r = v ^ (v << 13);
      r = r ^ (r >> 17);
      r = r ^ (r << 5);
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (go) begin
         hash_ff <= xs32(a + b);
      end
   end

   assign hash = hash_ff;

endmodule

>>> src/ogn_mul.sv
// Shared signed multiplier with round-half-up scaling by the fraction width or by 16.
module ogn_mul import ogn_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int MW        = FRAC_BITS_DEF + 18
) (
   input  logic                 clock,
   input  mul_ctl_type          ctl,
   input  logic signed [MW-1:0] a,
   input  logic signed [MW-1:0] b,
   output logic signed [MW-1:0] prod
);

   localparam int PW = 2 * MW;
   localparam logic signed [PW-1:0] RND_F  = PW'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [PW-1:0] RND_16 = PW'(1) <<< 15;

   logic signed [PW-1:0] full;
   logic signed [PW-1:0] scaled;
   logic signed [MW-1:0] prod_ff;

   always_comb begin
      full = PW'(a) * PW'(b);
      if (ctl.q16) begin
         scaled = (full + RND_16) >>> 16;
      end else begin
         scaled = (full + RND_F) >>> FRAC_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.go) begin
         prod_ff <= scaled[MW-1:0];
      end
   end

   assign prod = prod_ff;

endmodule

>>> src/ogn_div.sv
// Restoring divider, one quotient bit per cycle, for the final normalisation.
module ogn_div import ogn_pkg::*; #(
   parameter int XW = AMP_W + 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  logic [XW-1:0]     num_hi,
   input  logic [QUOT_W-1:0] num_lo,
   input  logic [XW-1:0]     den,
   output logic [QUOT_W-1:0] quot,
   output div_sts_type       sts
);

   localparam int CNT_W = $clog2(QUOT_W + 1);

   logic [XW-1:0]     rem_ff;
   logic [QUOT_W-1:0] lo_ff;
   logic [QUOT_W-1:0] q_ff;
   logic [XW-1:0]     den_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [XW:0]       r2;
   logic              ge;
   logic [XW:0]       diff;

   always_comb begin
      r2   = {rem_ff, lo_ff[QUOT_W-1]};
      ge   = (r2 >= {1'b0, den_ff});
      diff = r2 - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            rem_ff  <= num_hi;
            lo_ff   <= num_lo;
            den_ff  <= den;
            q_ff    <= '0;
            cnt_ff  <= CNT_W'(QUOT_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= ge ? diff[XW-1:0] : r2[XW-1:0];
            lo_ff  <= lo_ff << 1;
            q_ff   <= {q_ff[QUOT_W-2:0], ge};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quot     = q_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule

>>> src/ogn_checker.sv
// Port-level checks of the noise block and their binding to the top level.
module ogn_checker import ogn_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [OUT_W-1:0] noise_value
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("block still ready after taking a point");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("result word appeared straight after a point was taken");

   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("block not idle when a result word was posted");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(noise_value)))
      else $error("stalled result word changed");

endmodule

bind octave_gradient_noise_3d_top ogn_checker u_ogn_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .noise_value (rsp_ch.noise_value)
);

>>> test/testbench.sv
// Self-checking testbench for the fractal 3D gradient noise block.
module testbench import ogn_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint UNIT = 64'sd65536;

   class noise_scoreboard;
      logic [31:0] seed_reg;
      logic [3:0]  octave_reg;
      logic [16:0] persist_reg;
      logic [15:0] expected_noise[$];
      int          errors;

      function void clear_regs();
         seed_reg = 0;
         octave_reg = 1;
         persist_reg = 17'd32768;
      endfunction

      function void write_reg(csr_idx_type idx, logic [31:0] data);
         case (idx)
            CSR_SEED:    seed_reg = data;
            CSR_OCTAVES: octave_reg = data[3:0];
            CSR_PERSIST: persist_reg = data[16:0];
            default: ;
         endcase
      endfunction

      function longint qmul(longint a, longint b);
         longint hi, lo;
         hi = b >>> 16;
         lo = b - hi * UNIT;
         return a * hi + ((a * lo + 64'sd32768) >>> 16);
      endfunction

      function longint cell_of(longint v);
         if (v >= 0) return v >>> 16;
         return -((-v) >>> 16);
      endfunction

      function logic [31:0] xorshift(logic [31:0] v);
         v = v ^ (v << 13);
         v = v ^ (v >> 17);
         v = v ^ (v << 5);
         return v;
      endfunction

      function logic [31:0] lattice_hash(longint ix, longint iy, longint iz);
         logic [31:0] r;
         r = xorshift(ix[31:0] + seed_reg);
         r = xorshift(r + iy[31:0]);
         r = xorshift(r + iz[31:0]);
         return r;
      endfunction

      function longint grad(logic [31:0] h, longint x, longint y, longint z);
         case (h[3:0])
            4'h0: return x + y;
            4'h1: return -x + y;
            4'h2: return x - y;
            4'h3: return -x - y;
            4'h4: return x + z;
            4'h5: return -x + z;
            4'h6: return x - z;
            4'h7: return -x - z;
            4'h8: return y + z;
            4'h9: return -y + z;
            4'hA: return y - z;
            4'hB: return -y - z;
            4'hC: return y + x;
            4'hD: return -y + z;
            4'hE: return y - x;
            default: return -y - z;
         endcase
      endfunction

      function longint fade_curve(longint t);
         longint inner, t2, t3;
         inner = qmul(t, 6 * t - 15 * UNIT) + 10 * UNIT;
         t2 = qmul(t, t);
         t3 = qmul(t2, t);
         return qmul(t3, inner);
      endfunction

      function longint lerp(longint a, longint b, longint t);
         return a + qmul(t, b - a);
      endfunction

      function longint single_octave(longint x, longint y, longint z);
         longint x0, y0, z0, x1, y1, z1, fx, fy, fz, gx, gy, gz, u, v, w, a, b, p, q;
         x0 = cell_of(x); y0 = cell_of(y); z0 = cell_of(z);
         x1 = cell_of(x + UNIT); y1 = cell_of(y + UNIT); z1 = cell_of(z + UNIT);
         fx = x - x0 * UNIT; fy = y - y0 * UNIT; fz = z - z0 * UNIT;
         gx = fx - UNIT; gy = fy - UNIT; gz = fz - UNIT;
         u = fade_curve(fx); v = fade_curve(fy); w = fade_curve(fz);
         a = lerp(grad(lattice_hash(x0, y0, z0), fx, fy, fz),
                  grad(lattice_hash(x1, y0, z0), gx, fy, fz), u);
         b = lerp(grad(lattice_hash(x0, y1, z0), fx, gy, fz),
                  grad(lattice_hash(x1, y1, z0), gx, gy, fz), u);
         p = lerp(a, b, v);
         a = lerp(grad(lattice_hash(x0, y0, z1), fx, fy, gz),
                  grad(lattice_hash(x1, y0, z1), gx, fy, gz), u);
         b = lerp(grad(lattice_hash(x0, y1, z1), fx, gy, gz),
                  grad(lattice_hash(x1, y1, z1), gx, gy, gz), u);
         q = lerp(a, b, v);
         return (lerp(p, q, w) + UNIT) >>> 1;
      endfunction

      function logic [15:0] fractal_noise(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
         longint x, y, z, pers, amp, weight, total, n, res;
         int count;
         x = longint'($signed(px)); y = longint'($signed(py)); z = longint'($signed(pz));
         count = octave_reg;
         if (count < 1) count = 1;
         if (count > MAX_OCTAVES_DEF) count = MAX_OCTAVES_DEF;
         pers = (persist_reg > 17'd65536) ? 65536 : longint'(persist_reg);
         amp = 65536; weight = 0; total = 0;
         for (int i = 0; i < count; i++) begin
            n = single_octave(x <<< i, y <<< i, z <<< i);
            total += (n * amp + 32768) >>> 16;
            weight += amp;
            amp = (amp * pers + 32768) >>> 16;
         end
         if (total <= 0) res = 0;
         else if (total >= weight) res = 65535;
         else begin
            res = (total * 65536 + weight / 2) / weight;
            if (res > 65535) res = 65535;
         end
         return res[15:0];
      endfunction

      function void note_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
         expected_noise.push_back(fractal_noise(px, py, pz));
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_noise(logic [15:0] got);
         logic [15:0] want;
         if (expected_noise.size() == 0) begin
            report_mismatch($sformatf("unexpected word noise_value=%0d", got));
         end else begin
            want = expected_noise.pop_front();
            if (got !== want)
               report_mismatch($sformatf("noise_value %0d, expected %0d", got, want));
         end
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   bit   quiet = 0;
   noise_scoreboard sb = new();

   ogn_req_if req_ch();
   ogn_rsp_if rsp_ch();
   ogn_csr_if csr_ch();

   octave_gradient_noise_3d_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #6 clock = ~clock;

   function bit take_break();
      return !quiet && $urandom_range(99) < 19;
   endfunction

   task send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      if (take_break()) begin
         req_ch.valid = 0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_ch.valid = 1;
      req_ch.point_x = px;
      req_ch.point_y = py;
      req_ch.point_z = pz;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_point(px, py, pz);
      @(negedge clock);
   endtask

   task drain();
      req_ch.valid = 0;
      while (sb.expected_noise.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task write_reg(csr_idx_type idx, logic [31:0] data);
      csr_ch.valid = 1;
      csr_ch.index = idx;
      csr_ch.data = data;
      do @(posedge clock); while (!csr_ch.ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_ch.valid = 0;
   endtask

   task configure(logic [31:0] s, logic [31:0] oct, logic [31:0] pers);
      drain();
      write_reg(CSR_SEED, s);
      write_reg(CSR_OCTAVES, oct);
      write_reg(CSR_PERSIST, pers);
   endtask

   function logic [31:0] coord();
      case ($urandom_range(3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 20000000)) - 10000000);
         2: return 32'($signed($urandom_range(0, 600000)) - 300000);
         default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      endcase
   endfunction

   task random_points(int n);
      for (int i = 0; i < n; i++) begin
         send_point(coord(), coord(), coord());
         if (i == n / 2 && $urandom_range(1)) drain();
      end
   endtask

   initial begin
      rsp_ch.ready = 0;
      forever begin
         @(negedge clock);
         rsp_ch.ready = quiet || $urandom_range(99) >= 19;
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) sb.check_noise(rsp_ch.noise_value);
      end
   end

   initial begin
      #40ms;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      logic [31:0] edge_vals[12];
      edge_vals = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h00010000,
                    32'hFFFF0000, 32'h00008000, 32'hFFFF8000, 32'h0000FFFF,
                    32'hFFFF0001, 32'h00012345, 32'hFFFEDCBA};
      sb.clear_regs();
      req_ch.valid = 0; req_ch.point_x = 0; req_ch.point_y = 0; req_ch.point_z = 0;
      csr_ch.valid = 0; csr_ch.index = CSR_SEED; csr_ch.data = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      for (int i = 0; i < 12; i++)
         send_point(edge_vals[i], edge_vals[(i + 5) % 12], edge_vals[(i + 9) % 12]);
      configure(32'hFFFFFFFF, 0, 0);
      send_point(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
      send_point(32'hFFFF8000, 32'h00018000, 32'h0);
      configure(32'h12345678, 15, 32'h0001FFFF);
      send_point(32'h7FFFFFFF, 32'h80000000, 32'h00004000);
      send_point(32'hFFFFC000, 32'h00000001, 32'hFFFFFFFF);
      configure(0, 8, 65536);
      send_point(32'h00050000, 32'hFFFB0000, 32'h00028000);
      configure(0, 1, 32768);
      random_points(300);

      quiet = 1;
      configure($urandom(), 2, 0);
      random_points(350);
      quiet = 0;
      configure($urandom(), 0, $urandom_range(0, 65536));
      random_points(250);
      configure($urandom(), 3, 65536);
      random_points(300);
      configure($urandom(), 15, $urandom());
      random_points(120);
      configure($urandom(), 4, 32'h0001FFFF);
      random_points(200);
      configure(32'hFFFFFFFF, 1, $urandom_range(0, 65536));
      random_points(200);
      configure($urandom(), $urandom_range(1, 8), $urandom_range(0, 65536));
      random_points(100);

      drain();
      repeat (100) @(negedge clock);
      if (sb.errors == 0 && sb.expected_noise.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

>>> sim.f
src/ogn_pkg.sv
src/ogn_if.sv
src/ogn_hash.sv
src/ogn_mul.sv
src/ogn_div.sv
src/octave_gradient_noise_3d_top.sv
src/ogn_checker.sv
test/testbench.sv
